@@ rtl/crli_pkg.sv @@
// ----------------------------------------------------------------------------
// crli_pkg
// Shared types and constants of the circular record log index unit.
// ----------------------------------------------------------------------------
package crli_pkg;

   localparam int DEPTH_DEFAULT = 256;

   localparam int FIELD_W     = 16;
   localparam int BASE_W      = 16;
   localparam int SIZE_W      = 9;
   localparam int ADDR_W      = 17;
   localparam int COUNT_OUT_W = 9;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_IDX_W   = 1;
   localparam int MODE_W      = 3;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 32;

   localparam logic [BASE_W-1:0] BASE_ADDRESS_RESET = '0;
   localparam logic [SIZE_W-1:0] RECORD_SIZE_RESET  = 9'd16;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDRESS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RECORD_SIZE  = 1'd1;

   typedef enum logic [MODE_W-1:0] {
      MODE_APPEND      = 3'd0,
      MODE_READ_UNSENT = 3'd1,
      MODE_READ_LATEST = 3'd2,
      MODE_ADVANCE     = 3'd3,
      MODE_CLEAR       = 3'd4
   } mode_type;

   typedef struct packed {
      mode_type           mode;
      logic [FIELD_W-1:0] offset;
      logic [FIELD_W-1:0] advance_by;
      logic               write_failed;
   } crli_cmd_type;

   // ok in the lowest bit, then address, then stored_count
   typedef struct packed {
      logic [COUNT_OUT_W-1:0] stored_count;
      logic [ADDR_W-1:0]      address;
      logic                   ok;
   } crli_rsp_type;

endpackage

@@ rtl/circular_record_log_index_unit.sv @@
// ----------------------------------------------------------------------------
// circular_record_log_index_unit
// Index manager for a ring of record slots that overwrites the oldest record.
// ----------------------------------------------------------------------------
// One command word is taken every cycle unless rsp_tready holds the output
// back, and result words leave in command order through four registered
// stages (advance count quotient, remainder fix-up, index update, address
// multiply-add). The index and count registers update on each command taken,
// so back-to-back commands see each other's effect. No pass runs after reset.
module circular_record_log_index_unit import crli_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // offset [15:0], advance_by [31:16], write_failed [32], zero [39:33]
   input  logic [REQ_DATA_W-1:0]   req_tdata,
   // mode [2:0]
   input  logic [MODE_W-1:0]       req_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // ok [0], address [17:1], stored_count [26:18], zero [31:27]
   output logic [RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                    csr_wen,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH+1);

   logic [BASE_W-1:0] base_ff;
   logic [SIZE_W-1:0] size_ff;

   crli_cmd_type      req_cmd;
   logic              am_ready;
   logic              am_valid, core_ready;
   crli_cmd_type      am_cmd;
   logic [IDX_W-1:0]  am_adv;
   logic              core_valid, addr_ready;
   logic              core_ok;
   logic [IDX_W-1:0]  core_slot;
   logic [CNT_W-1:0]  core_count;
   crli_rsp_type      rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= BASE_ADDRESS_RESET;
         size_ff <= RECORD_SIZE_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_BASE_ADDRESS: base_ff <= csr_wdata[BASE_W-1:0];
            CSR_RECORD_SIZE:  size_ff <= csr_wdata[SIZE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      req_cmd.mode         = mode_type'(req_tuser);
      req_cmd.offset       = req_tdata[FIELD_W-1:0];
      req_cmd.advance_by   = req_tdata[2*FIELD_W-1:FIELD_W];
      req_cmd.write_failed = req_tdata[2*FIELD_W];
   end

   assign req_tready = am_ready && !reset;

   crli_advmod #(.DEPTH(DEPTH)) u_advmod (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid && !reset),
      .in_ready  (am_ready),
      .in_cmd    (req_cmd),
      .out_valid (am_valid),
      .out_ready (core_ready),
      .out_cmd   (am_cmd),
      .out_adv   (am_adv)
   );

   crli_core #(.DEPTH(DEPTH)) u_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (am_valid),
      .in_ready  (core_ready),
      .in_cmd    (am_cmd),
      .in_adv    (am_adv),
      .out_valid (core_valid),
      .out_ready (addr_ready),
      .out_ok    (core_ok),
      .out_slot  (core_slot),
      .out_count (core_count)
   );

   crli_addr #(.DEPTH(DEPTH)) u_addr (
      .clock        (clock),
      .reset        (reset),
      .base_address (base_ff),
      .record_size  (size_ff),
      .in_valid     (core_valid),
      .in_ready     (addr_ready),
      .in_ok        (core_ok),
      .in_slot      (core_slot),
      .in_count     (core_count),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_rsp      (rsp)
   );

   assign rsp_tdata = {(RSP_DATA_W - $bits(crli_rsp_type))'(0), rsp};

endmodule

@@ rtl/crli_advmod.sv @@
// ----------------------------------------------------------------------------
// crli_advmod
// Two-stage reduction of the advance count modulo the ring depth.
// ----------------------------------------------------------------------------
module crli_advmod import crli_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  crli_cmd_type               in_cmd,
   output logic                       out_valid,
   input  logic                       out_ready,
   output crli_cmd_type               out_cmd,
   output logic [$clog2(DEPTH)-1:0]   out_adv
);

   localparam int IDX_W    = $clog2(DEPTH);
   localparam int RECIP_SH = 17;
   localparam int PROD_W   = FIELD_W + RECIP_SH + 1;
   localparam logic [RECIP_SH:0]  RECIP   = (RECIP_SH+1)'((2**RECIP_SH) / DEPTH);
   localparam logic [FIELD_W-1:0] DEPTH_F = FIELD_W'(DEPTH);

   logic                 a_valid_ff, a_valid_in;
   crli_cmd_type         a_cmd_ff;
   logic [FIELD_W-1:0]   a_quot_ff, a_quot_in;
   logic                 b_valid_ff, b_valid_in;
   crli_cmd_type         b_cmd_ff;
   logic [IDX_W-1:0]     b_adv_ff, b_adv_in;
   logic                 a_ready, b_ready;
   logic [PROD_W-1:0]    prod;
   logic [FIELD_W-1:0]   quot_mul, rem;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   // quotient estimate, low by at most one
   assign prod      = PROD_W'(in_cmd.advance_by) * PROD_W'(RECIP);
   assign a_quot_in = prod[RECIP_SH +: FIELD_W];

   assign quot_mul  = a_quot_ff * DEPTH_F;
   assign rem       = a_cmd_ff.advance_by - quot_mul;
   assign b_adv_in  = (rem >= DEPTH_F) ? IDX_W'(rem - DEPTH_F) : IDX_W'(rem);

   assign a_valid_in = a_ready ? in_valid : a_valid_ff;
   assign b_valid_in = b_ready ? a_valid_ff : b_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
      if (in_valid && a_ready) begin
         a_cmd_ff  <= in_cmd;
         a_quot_ff <= a_quot_in;
      end
      if (a_valid_ff && b_ready) begin
         b_cmd_ff <= a_cmd_ff;
         b_adv_ff <= b_adv_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_cmd   = b_cmd_ff;
   assign out_adv   = b_adv_ff;

endmodule

@@ rtl/crli_core.sv @@
// ----------------------------------------------------------------------------
// crli_core
// Write index, read index and record count; picks the slot for each command.
// ----------------------------------------------------------------------------
module crli_core import crli_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  crli_cmd_type                 in_cmd,
   input  logic [$clog2(DEPTH)-1:0]     in_adv,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic                         out_ok,
   output logic [$clog2(DEPTH)-1:0]     out_slot,
   output logic [$clog2(DEPTH+1)-1:0]   out_count
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH+1);
   localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W+1)'(DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH-1);
   localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);

   logic [IDX_W-1:0] widx_ff, widx_in;
   logic [IDX_W-1:0] ridx_ff, ridx_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             valid_ff, valid_in;
   logic             ok_ff, ok_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0] cnt_out_ff;
   logic             take;
   logic             in_range;
   logic [IDX_W-1:0] off_idx;
   logic [IDX_W-1:0] unsent_slot, latest_slot;

   function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
      logic [IDX_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= DEPTH_X) begin
         sum = sum - DEPTH_X;
      end
      return sum[IDX_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] step(input logic [IDX_W-1:0] a);
      return (a == LAST_IDX) ? '0 : a + 1'b1;
   endfunction

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   assign in_range    = in_cmd.offset < FIELD_W'(cnt_ff);
   assign off_idx     = in_cmd.offset[IDX_W-1:0];
   assign unsent_slot = wrap_add(ridx_ff, off_idx);
   assign latest_slot = wrap_add(widx_ff, LAST_IDX - off_idx);

   always_comb begin
      widx_in = widx_ff;
      ridx_in = ridx_ff;
      cnt_in  = cnt_ff;
      ok_in   = 1'b0;
      slot_in = '0;
      unique case (in_cmd.mode)
         MODE_APPEND: begin
            if (!in_cmd.write_failed) begin
               ok_in   = 1'b1;
               slot_in = widx_ff;
               widx_in = step(widx_ff);
               if (widx_in == ridx_ff) begin
                  ridx_in = step(ridx_ff);
               end
               if (cnt_ff < DEPTH_C) begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         MODE_READ_UNSENT: begin
            if (in_range && (unsent_slot != widx_ff)) begin
               ok_in   = 1'b1;
               slot_in = unsent_slot;
            end
         end
         MODE_READ_LATEST: begin
            if (in_range) begin
               ok_in   = 1'b1;
               slot_in = latest_slot;
            end
         end
         MODE_ADVANCE: begin
            ridx_in = wrap_add(ridx_ff, in_adv);
            ok_in   = 1'b1;
            slot_in = ridx_in;
         end
         MODE_CLEAR: begin
            ridx_in = widx_ff;
            cnt_in  = '0;
            ok_in   = 1'b1;
            slot_in = widx_ff;
         end
         default: begin
         end
      endcase
   end

   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         widx_ff  <= '0;
         ridx_ff  <= '0;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (take) begin
            widx_ff <= widx_in;
            ridx_ff <= ridx_in;
            cnt_ff  <= cnt_in;
         end
      end
      if (take) begin
         ok_ff      <= ok_in;
         slot_ff    <= slot_in;
         cnt_out_ff <= cnt_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ok    = ok_ff;
   assign out_slot  = slot_ff;
   assign out_count = cnt_out_ff;

endmodule

@@ rtl/crli_addr.sv @@
// ----------------------------------------------------------------------------
// crli_addr
// Forms the record address and holds the result word for the output side.
// ----------------------------------------------------------------------------
module crli_addr import crli_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [BASE_W-1:0]            base_address,
   input  logic [SIZE_W-1:0]            record_size,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic                         in_ok,
   input  logic [$clog2(DEPTH)-1:0]     in_slot,
   input  logic [$clog2(DEPTH+1)-1:0]   in_count,
   output logic                         out_valid,
   input  logic                         out_ready,
   output crli_rsp_type                 out_rsp
);

   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH+1);
   localparam int PROD_W = IDX_W + SIZE_W;
   localparam int SUM_W  = PROD_W + BASE_W + 1;

   logic               valid_ff, valid_in;
   crli_rsp_type       rsp_ff, rsp_in;
   logic [PROD_W-1:0]  prod;
   logic [SUM_W-1:0]   sum;
   logic [CNT_W+COUNT_OUT_W-1:0] cnt_wide;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   assign prod     = PROD_W'(in_slot) * PROD_W'(record_size);
   assign sum      = SUM_W'(base_address) + SUM_W'(prod);
   assign cnt_wide = {{COUNT_OUT_W{1'b0}}, in_count};

   always_comb begin
      rsp_in.ok           = in_ok;
      rsp_in.address      = in_ok ? sum[ADDR_W-1:0] : '0;
      rsp_in.stored_count = cnt_wide[COUNT_OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

@@ rtl/crli_checker.sv @@
// ----------------------------------------------------------------------------
// crli_checker
// Port-level checks of the circular record log index unit.
// ----------------------------------------------------------------------------
module crli_checker import crli_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam logic [2:0] MAX_IN_FLIGHT = 3'd4;

   logic [2:0] pending_ff, pending_in;
   logic       req_take, rsp_take;

   assign req_take   = req_tvalid && req_tready;
   assign rsp_take   = rsp_tvalid && rsp_tready;
   assign pending_in = pending_ff + 3'(req_take) - 3'(rsp_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (pending_ff != 3'd0) && (pending_ff <= MAX_IN_FLIGHT))
      else $error("result word without a matching command word");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[ADDR_W:1] == '0)
      else $error("rejected command carries an address");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> 32'(rsp_tdata[ADDR_W+COUNT_OUT_W:ADDR_W+1]) <= DEPTH)
      else $error("record count above ring depth");

endmodule

bind circular_record_log_index_unit crli_checker #(.DEPTH(DEPTH)) u_crli_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ bench/tb_circular_record_log_index_unit.sv @@
// ----------------------------------------------------------------------------
// tb_circular_record_log_index_unit
// Self-checking bench for the circular record log index unit.
// ----------------------------------------------------------------------------
// Commands go in on the req stream and results come back on the rsp stream.
// An in-bench model of the write index, read index and saturating record
// count predicts one result per accepted command. Each result is checked
// field by field against the oldest prediction. A short directed list covers
// the empty log, failed appends, reads that fall on the write slot, full-ring
// advances and the unused mode codes. Random traffic follows, mixed with long
// append runs so that the ring fills and overwrites its oldest record. The
// run goes through several base and stride settings, including a zero stride
// and strides that wrap the address. Both sides stall at random, and once the
// receiver holds off long enough to back the pipeline up into the sender.
// ----------------------------------------------------------------------------
module tb_circular_record_log_index_unit;
   import crli_pkg::*;

   localparam int LOG_DEPTH        = DEPTH_DEFAULT;
   localparam int IDX_W            = $clog2(LOG_DEPTH);
   localparam int FLUSH_CYCLES     = 12;
   localparam int CYCLE_LIMIT      = 600000;
   localparam int LONG_HOLD_CYCLES = 120;
   localparam int LONG_HOLD_AFTER  = 300;
   localparam int SETTINGS_COUNT   = 6;
   localparam logic [MODE_W-1:0] MODE_CODE_MAX = '1;

   typedef struct {
      logic [MODE_W-1:0]  mode;
      logic [FIELD_W-1:0] offset;
      logic [FIELD_W-1:0] advance_by;
      logic               write_failed;
   } log_command_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // offset [15:0], advance_by [31:16], write_failed [32], zero [39:33]
   logic [REQ_DATA_W-1:0] req_tdata;
   // mode [2:0]
   logic [MODE_W-1:0]     req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // ok [0], address [17:1], stored_count [26:18], zero [31:27]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wen;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   log_command_type commands_to_send[$];
   crli_rsp_type expected_replies[$];

   logic [BASE_W-1:0]      log_base;
   logic [SIZE_W-1:0]      log_stride;
   logic [IDX_W-1:0]       write_slot;
   logic [IDX_W-1:0]       read_slot;
   logic [COUNT_OUT_W-1:0] record_total;

   int  cycle_count;
   int  fail_count;
   int  commands_taken;
   int  replies_checked;
   int  appends_done;
   int  overwrites_seen;
   int  reads_refused;
   int  settings_used;
   logic cmd_taken;
   int  send_gap;
   int  send_calm;
   int  hold_left;
   int  hold_calm;
   bit  long_hold_done;

   circular_record_log_index_unit #(
      .DEPTH(LOG_DEPTH)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [ADDR_W-1:0] slot_address(input logic [IDX_W-1:0] slot);
      logic [31:0] sum;
      sum = 32'(log_base) + 32'(slot) * 32'(log_stride);
      return sum[ADDR_W-1:0];
   endfunction

   // advance the log state by one command and return the reply it produces
   function automatic crli_rsp_type log_step(input log_command_type cmd);
      crli_rsp_type reply;
      logic [IDX_W-1:0] slot;
      reply = '0;
      case (cmd.mode)
         MODE_APPEND: begin
            if (!cmd.write_failed) begin
               reply.ok      = 1'b1;
               reply.address = slot_address(write_slot);
               write_slot    = IDX_W'((int'(write_slot) + 1) % LOG_DEPTH);
               if (write_slot == read_slot) begin
                  read_slot = IDX_W'((int'(read_slot) + 1) % LOG_DEPTH);
                  overwrites_seen++;
               end
               if (record_total < LOG_DEPTH) record_total = record_total + 1'b1;
               appends_done++;
            end
         end
         MODE_READ_UNSENT: begin
            slot = IDX_W'((int'(read_slot) + int'(cmd.offset)) % LOG_DEPTH);
            if (cmd.offset < record_total && slot != write_slot) begin
               reply.ok      = 1'b1;
               reply.address = slot_address(slot);
            end else begin
               reads_refused++;
            end
         end
         MODE_READ_LATEST: begin
            if (cmd.offset < record_total) begin
               slot = IDX_W'((int'(write_slot) + LOG_DEPTH - 1 - int'(cmd.offset)) % LOG_DEPTH);
               reply.ok      = 1'b1;
               reply.address = slot_address(slot);
            end else begin
               reads_refused++;
            end
         end
         MODE_ADVANCE: begin
            read_slot     = IDX_W'((int'(read_slot) + int'(cmd.advance_by)) % LOG_DEPTH);
            reply.ok      = 1'b1;
            reply.address = slot_address(read_slot);
         end
         MODE_CLEAR: begin
            read_slot     = write_slot;
            record_total  = '0;
            reply.ok      = 1'b1;
            reply.address = slot_address(read_slot);
         end
         default: begin
         end
      endcase
      reply.stored_count = record_total;
      return reply;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // mostly short gaps, some longer, a few long; calm stretches run gap-free
   function automatic int pick_gap(inout int calm);
      int roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 49) == 0) calm = $urandom_range(20, 60);
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic void push_cmd(input logic [MODE_W-1:0] mode,
                                    input logic [FIELD_W-1:0] offset,
                                    input logic [FIELD_W-1:0] advance_by,
                                    input logic write_failed);
      log_command_type cmd;
      cmd.mode         = mode;
      cmd.offset       = offset;
      cmd.advance_by   = advance_by;
      cmd.write_failed = write_failed;
      commands_to_send.push_back(cmd);
   endfunction

   function automatic logic [FIELD_W-1:0] random_position(input int near_max);
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 6) return FIELD_W'($urandom_range(0, near_max));
      if (roll < 8) return FIELD_W'($urandom_range(0, 16));
      return FIELD_W'($urandom);
   endfunction

   function automatic log_command_type random_command();
      log_command_type cmd;
      int roll;
      cmd.offset       = random_position(260);
      cmd.advance_by   = random_position(300);
      cmd.write_failed = ($urandom_range(0, 9) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 40) cmd.mode = MODE_APPEND;
      else if (roll < 60) cmd.mode = MODE_READ_UNSENT;
      else if (roll < 78) cmd.mode = MODE_READ_LATEST;
      else if (roll < 88) cmd.mode = MODE_ADVANCE;
      else if (roll < 90) cmd.mode = MODE_CLEAR;
      else if (roll < 96) begin
         cmd.mode         = MODE_W'($urandom);
         cmd.offset       = FIELD_W'($urandom);
         cmd.advance_by   = FIELD_W'($urandom);
         cmd.write_failed = 1'($urandom_range(0, 1));
      end else begin
         cmd.mode = MODE_W'($urandom_range(int'(MODE_CLEAR) + 1, int'(MODE_CODE_MAX)));
      end
      return cmd;
   endfunction

   // random traffic mixed with bursts of appends
   task automatic queue_random(input int count);
      int left;
      int run;
      left = count;
      while (left > 0) begin
         if ($urandom_range(0, 29) == 0) begin
            run = $urandom_range(20, 90);
            if (run > left) run = left;
            repeat (run) push_cmd(MODE_APPEND, FIELD_W'($urandom), FIELD_W'($urandom),
                                  $urandom_range(0, 19) == 0);
            left -= run;
         end else begin
            commands_to_send.push_back(random_command());
            left--;
         end
      end
   endtask

   task automatic wait_drained();
      while (commands_to_send.size() != 0 || req_tvalid || expected_replies.size() != 0)
         @(posedge clock);
      repeat (FLUSH_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen <= 1'b0;
      if (idx == CSR_BASE_ADDRESS) log_base = value;
      else log_stride = value[SIZE_W-1:0];
   endtask

   always @(negedge clock) begin
      log_command_type cmd;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || cmd_taken) begin
         if (send_gap > 0) begin
            req_tvalid <= 1'b0;
            send_gap--;
         end else if (commands_to_send.size() != 0) begin
            cmd = commands_to_send.pop_front();
            req_tuser  <= cmd.mode;
            req_tdata  <= {7'd0, cmd.write_failed, cmd.advance_by, cmd.offset};
            req_tvalid <= 1'b1;
            send_gap = pick_gap(send_calm);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_left > 0) begin
            hold_left--;
         end else if (!long_hold_done && replies_checked >= LONG_HOLD_AFTER) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
         end else begin
            hold_left = pick_gap(hold_calm);
         end
         rsp_tready <= (hold_left == 0);
      end
   end

   always @(posedge clock) begin
      crli_rsp_type got;
      crli_rsp_type want;
      log_command_type cmd;
      cycle_count++;
      if (reset) begin
         cmd_taken <= 1'b0;
      end else begin
         cmd_taken <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            got = crli_rsp_type'(rsp_tdata[$bits(crli_rsp_type)-1:0]);
            if (expected_replies.size() == 0) begin
               $display("%0t: result with nothing outstanding, expected none, actual %h",
                        $time, rsp_tdata);
               fail_count++;
            end else begin
               want = expected_replies.pop_front();
               check_field("ok", want.ok, got.ok);
               check_field("address", want.address, got.address);
               check_field("stored_count", want.stored_count, got.stored_count);
            end
            replies_checked++;
         end
         if (req_tvalid && req_tready) begin
            cmd.mode         = req_tuser;
            cmd.offset       = req_tdata[15:0];
            cmd.advance_by   = req_tdata[31:16];
            cmd.write_failed = req_tdata[32];
            expected_replies.push_back(log_step(cmd));
            commands_taken++;
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, expected_replies.size());
         $display("tb_circular_record_log_index_unit: errors");
         $finish;
      end
   end

   initial begin
      logic [BASE_W-1:0] bases [SETTINGS_COUNT];
      logic [SIZE_W-1:0] strides [SETTINGS_COUNT];
      bases   = '{16'hFFFF, 16'd0, 16'd12345, 16'd777, 16'hFFFF, 16'd0};
      strides = '{9'd256, 9'd1, 9'd511, 9'd0, 9'd511, 9'd16};
      bases[SETTINGS_COUNT-1]   = BASE_W'($urandom);
      strides[SETTINGS_COUNT-1] = SIZE_W'($urandom_range(1, 256));

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = MODE_APPEND;
      rsp_tready = 1'b0;
      csr_wen    = 1'b0;
      csr_index  = CSR_BASE_ADDRESS;
      csr_wdata  = '0;
      cmd_taken  = 1'b0;
      log_base     = BASE_ADDRESS_RESET;
      log_stride   = RECORD_SIZE_RESET;
      write_slot   = '0;
      read_slot    = '0;
      record_total = '0;
      settings_used = 1;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty log, then one record: hit the write slot, failed append, full ring
      push_cmd(MODE_READ_UNSENT, 16'd0, 16'd0, 1'b0);
      push_cmd(MODE_READ_LATEST, 16'd0, 16'd0, 1'b0);
      push_cmd(MODE_APPEND, 16'hFFFF, 16'hFFFF, 1'b1);
      push_cmd(MODE_APPEND, 16'd0, 16'd0, 1'b0);
      push_cmd(MODE_READ_UNSENT, 16'd0, 16'd0, 1'b0);
      push_cmd(MODE_READ_UNSENT, 16'd1, 16'd0, 1'b0);
      push_cmd(MODE_READ_LATEST, 16'd0, 16'd0, 1'b0);
      push_cmd(MODE_READ_LATEST, 16'hFFFF, 16'd0, 1'b0);
      push_cmd(MODE_ADVANCE, 16'd0, 16'd1, 1'b0);
      push_cmd(MODE_READ_UNSENT, 16'd0, 16'd0, 1'b0);
      push_cmd(MODE_ADVANCE, 16'd0, 16'd0, 1'b0);
      push_cmd(MODE_ADVANCE, 16'd0, 16'hFFFF, 1'b0);
      push_cmd(MODE_ADVANCE, 16'd0, 16'(LOG_DEPTH), 1'b0);
      push_cmd(MODE_CLEAR, 16'hFFFF, 16'hFFFF, 1'b1);
      for (int m = int'(MODE_CLEAR) + 1; m <= int'(MODE_CODE_MAX); m++)
         push_cmd(MODE_W'(m), 16'hFFFF, 16'hFFFF, 1'b1);
      repeat (3) push_cmd(MODE_APPEND, 16'd0, 16'd0, 1'b0);
      push_cmd(MODE_READ_LATEST, 16'd2, 16'd0, 1'b0);
      push_cmd(MODE_READ_LATEST, 16'd3, 16'd0, 1'b0);
      push_cmd(MODE_READ_UNSENT, 16'd2, 16'd0, 1'b0);
      push_cmd(MODE_CLEAR, 16'd0, 16'd0, 1'b0);

      queue_random(400);
      wait_drained();

      for (int s = 0; s < SETTINGS_COUNT; s++) begin
         write_reg(CSR_BASE_ADDRESS, CSR_DATA_W'(bases[s]));
         write_reg(CSR_RECORD_SIZE, CSR_DATA_W'(strides[s]));
         settings_used++;
         queue_random(140);
         wait_drained();
      end

      if (expected_replies.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, expected_replies.size());
         fail_count++;
      end
      $display("covered %0d commands under %0d base/stride settings, %0d results checked",
               commands_taken, settings_used, replies_checked);
      $display("%0d appends, %0d overwrote the oldest record, %0d reads refused",
               appends_done, overwrites_seen, reads_refused);
      if (fail_count == 0) begin
         $display("tb_circular_record_log_index_unit: clean");
      end else begin
         $display("tb_circular_record_log_index_unit: errors");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/crli_pkg.sv
rtl/crli_advmod.sv
rtl/crli_core.sv
rtl/crli_addr.sv
rtl/circular_record_log_index_unit.sv
rtl/crli_checker.sv
bench/tb_circular_record_log_index_unit.sv
